>>> design/bmhpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhpq_pkg
// Types and codes shared by the max-heap priority queue unit and its store.
// ----------------------------------------------------------------------------
package bmhpq_pkg;

    localparam int KEY_W  = 32;
    localparam int DATA_W = 32;
    localparam int OCC_W  = 9;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_PEEK   = 2'd2;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef struct packed {
        logic [1:0]               func;
        logic signed [KEY_W-1:0]  key;
        logic signed [DATA_W-1:0] payload;
    } req_t;

    typedef struct packed {
        logic                     status;
        logic                     is_empty;
        logic signed [DATA_W-1:0] top_data;
        logic signed [KEY_W-1:0]  top_key;
        logic [OCC_W-1:0]         occupancy;
    } rsp_t;

    typedef struct packed {
        logic signed [KEY_W-1:0]  key;
        logic signed [DATA_W-1:0] data;
    } entry_t;

endpackage

>>> design/bmhpq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhpq_ram
// Heap entry store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module bmhpq_ram
    import bmhpq_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output entry_t        rdata_a,
    output entry_t        rdata_b
);

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read-first: a read of the address being written returns the old entry;
    // callers never use such a read.
    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

>>> design/binary_max_heap_priority_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_max_heap_priority_queue_unit
// Binary max-heap of (key, payload) pairs held in a synchronous RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall / req): func selects insert,
//   remove-top or peek; key and payload matter for insert only. A request is
//   taken when req_valid is high and req_stall low. One item is worked on at
//   a time; req_stall is high from acceptance until its result is registered.
//   Response channel (rsp_valid / rsp_stall / rsp): exactly one result per
//   item: status, empty flag, top key/data (zero when empty), occupancy.
//   A peek, a failing request, an insert into an empty heap or a remove of
//   the only entry goes straight to the response stage. Any other insert
//   sifts up and any other remove first fetches the last entry and then
//   sifts down, moving at most log2(CAPACITY) entries (8 for 256 entries).
//   At each level the RAM read issued before is compared and the moved
//   entry written back, while the read for the next level is issued.
//   The root entry is cached in a register so results never need a read.
//   Reset clears the count and the handshake; the RAM is not cleared since
//   only entries below the count are ever read.
//   A stalled response holds its value; a finished item waits in the
//   response stage and the next request is taken once it has moved on.
// ----------------------------------------------------------------------------
module binary_max_heap_priority_queue_unit
    import bmhpq_pkg::*;
#(
    parameter int CAPACITY = 256
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = AW + 2;   // child index math: up to 2*CAPACITY

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_CMP,     // compare with parent, swap or settle
        ST_UP_PLACE,   // sifted to root: write new entry there
        ST_DN_LAST,    // last entry arrives from RAM
        ST_DN_CMP,     // compare with larger child, swap or settle
        ST_DN_PLACE,   // reached a leaf: write entry there
        ST_RESP
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] idx_reg, idx_next;
    entry_t        cur_reg, cur_next;
    entry_t        root_reg, root_next;
    logic          fail_reg, fail_next;
    logic          rsp_valid_reg, rsp_valid_next;
    rsp_t          rsp_reg, rsp_next;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    entry_t        mem_wdata;
    logic [AW-1:0] rd_a_addr, rd_b_addr;
    entry_t        rd_a, rd_b;

    bmhpq_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (rd_a_addr),
        .raddr_b (rd_b_addr),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    // Sift-up addressing
    logic [AW-1:0] cnt_a;
    logic [AW-1:0] par_idx;        // parent of current index
    logic [AW-1:0] par_of_cnt;     // parent of the new tail slot
    logic [AW-1:0] par_of_par;     // grandparent

    // Sift-down addressing
    logic [XW-1:0] n_x;
    logic [XW-1:0] l_x, r_x, c_x, cl_x, cr_x;
    logic          use_r;
    entry_t        child;

    logic [CW+OCC_W-1:0] occ_ext;
    entry_t              new_entry;

    assign cnt_a      = count_reg[AW-1:0];
    assign par_idx    = (idx_reg - AW'(1)) >> 1;
    assign par_of_cnt = (cnt_a - AW'(1)) >> 1;
    assign par_of_par = (par_idx - AW'(1)) >> 1;

    assign n_x   = XW'(count_reg);
    assign l_x   = (XW'(idx_reg) << 1) + XW'(1);
    assign r_x   = l_x + XW'(1);
    assign use_r = (r_x < n_x) && !($signed(rd_a.key) > $signed(rd_b.key));
    assign child = use_r ? rd_b : rd_a;
    assign c_x   = use_r ? r_x : l_x;
    assign cl_x  = (c_x << 1) + XW'(1);
    assign cr_x  = cl_x + XW'(1);

    assign new_entry.key  = req.key;
    assign new_entry.data = req.payload;

    assign occ_ext = (CW + OCC_W)'(count_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        cur_next       = cur_reg;
        fail_next      = fail_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = cur_reg;
        rd_a_addr      = '0;
        rd_b_addr      = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    fail_next  = 1'b0;
                    state_next = ST_RESP;
                    case (req.func)
                        FUNC_INSERT:
                        begin
                            if (count_reg >= CW'(CAPACITY))
                            begin
                                fail_next = 1'b1;
                            end
                            else
                            begin
                                count_next = count_reg + CW'(1);
                                cur_next   = new_entry;
                                idx_next   = cnt_a;
                                if (count_reg == '0)
                                begin
                                    mem_we    = 1'b1;
                                    mem_waddr = '0;
                                    mem_wdata = new_entry;
                                end
                                else
                                begin
                                    rd_a_addr  = par_of_cnt;
                                    state_next = ST_UP_CMP;
                                end
                            end
                        end
                        FUNC_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                fail_next = 1'b1;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                                idx_next   = '0;
                                if (count_reg != CW'(1))
                                begin
                                    rd_a_addr  = AW'(count_reg - CW'(1));
                                    state_next = ST_DN_LAST;
                                end
                            end
                        end
                        default:
                        begin
                            // peek and the unused code
                            fail_next = (count_reg == '0);
                        end
                    endcase
                end
            end

            ST_UP_CMP:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                if ($signed(rd_a.key) < $signed(cur_reg.key))
                begin
                    mem_wdata = rd_a;
                    idx_next  = par_idx;
                    if (par_idx == '0)
                    begin
                        state_next = ST_UP_PLACE;
                    end
                    else
                    begin
                        rd_a_addr = par_of_par;
                    end
                end
                else
                begin
                    mem_wdata  = cur_reg;
                    state_next = ST_RESP;
                end
            end

            ST_UP_PLACE, ST_DN_PLACE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg;
                mem_wdata  = cur_reg;
                state_next = ST_RESP;
            end

            ST_DN_LAST:
            begin
                cur_next = rd_a;
                if (n_x <= XW'(1))
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = '0;
                    mem_wdata  = rd_a;
                    state_next = ST_RESP;
                end
                else
                begin
                    rd_a_addr  = AW'(l_x);
                    rd_b_addr  = AW'(r_x);
                    state_next = ST_DN_CMP;
                end
            end

            ST_DN_CMP:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                if ($signed(cur_reg.key) < $signed(child.key))
                begin
                    mem_wdata = child;
                    idx_next  = AW'(c_x);
                    if (cl_x >= n_x)
                    begin
                        state_next = ST_DN_PLACE;
                    end
                    else
                    begin
                        rd_a_addr = AW'(cl_x);
                        rd_b_addr = AW'(cr_x);
                    end
                end
                else
                begin
                    mem_wdata  = cur_reg;
                    state_next = ST_RESP;
                end
            end

            ST_RESP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next     = 1'b1;
                    rsp_next.status    = fail_reg ? STATUS_FAIL : STATUS_OK;
                    rsp_next.is_empty  = (count_reg == '0);
                    rsp_next.top_data  = (count_reg == '0) ? '0 : root_reg.data;
                    rsp_next.top_key   = (count_reg == '0) ? '0 : root_reg.key;
                    rsp_next.occupancy = occ_ext[OCC_W-1:0];
                    state_next         = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Root cache follows every write to slot 0
    always_comb
    begin
        root_next = root_reg;
        if (mem_we && (mem_waddr == '0))
        begin
            root_next = mem_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            cur_reg       <= '0;
            root_reg      <= '0;
            fail_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            cur_reg       <= cur_next;
            root_reg      <= root_next;
            fail_reg      <= fail_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> test/bmhpq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhpq_checker
// Keeps its own max-heap and checks every response of the queue unit in order.
// ----------------------------------------------------------------------------
module bmhpq_checker
    import bmhpq_pkg::*;
#(
    parameter int DEPTH = 256
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_stall,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_stall,
    input  rsp_t rsp,
    output int   mismatches,
    output int   outstanding
);

    localparam int PRINT_CAP = 100;

    entry_t heap_slot [DEPTH];
    int     heap_size;
    rsp_t   results_due [$];
    int     error_total;

    initial begin
        heap_size   = 0;
        error_total = 0;
        mismatches  = 0;
        outstanding = 0;
    end

    task automatic report_mismatch(string msg);
        if (error_total < PRINT_CAP)
            $display("%0t: ERROR %s", $time, msg);
        error_total++;
    endtask

    function automatic void swap_slots(int a, int b);
        entry_t tmp;
        tmp          = heap_slot[a];
        heap_slot[a] = heap_slot[b];
        heap_slot[b] = tmp;
    endfunction

    // move a new tail entry up while its parent is strictly smaller
    function automatic void sift_up(int start);
        int  idx;
        int  parent;
        bit  done;
        idx  = start;
        done = 1'b0;
        while (idx > 0 && !done) begin
            parent = (idx - 1) / 2;
            if ($signed(heap_slot[parent].key) < $signed(heap_slot[idx].key)) begin
                swap_slots(parent, idx);
                idx = parent;
            end else
                done = 1'b1;
        end
    endfunction

    // push the root down; equal child keys pick the right child
    function automatic void sift_down();
        int  idx;
        int  left;
        int  child;
        bit  done;
        idx  = 0;
        done = 1'b0;
        while (2 * idx + 1 < heap_size && !done) begin
            left  = 2 * idx + 1;
            child = left;
            if (left + 1 < heap_size &&
                !($signed(heap_slot[left].key) > $signed(heap_slot[left + 1].key)))
                child = left + 1;
            if ($signed(heap_slot[idx].key) < $signed(heap_slot[child].key)) begin
                swap_slots(idx, child);
                idx = child;
            end else
                done = 1'b1;
        end
    endfunction

    function automatic rsp_t heap_result(req_t r);
        rsp_t res;
        logic fail;
        fail = 1'b0;
        case (r.func)
            FUNC_INSERT:
            begin
                if (heap_size >= DEPTH)
                    fail = 1'b1;
                else begin
                    heap_slot[heap_size].key  = r.key;
                    heap_slot[heap_size].data = r.payload;
                    heap_size++;
                    sift_up(heap_size - 1);
                end
            end
            FUNC_REMOVE:
            begin
                if (heap_size == 0)
                    fail = 1'b1;
                else begin
                    heap_size--;
                    heap_slot[0] = heap_slot[heap_size];
                    sift_down();
                end
            end
            default: fail = (heap_size == 0);   // peek and the spare code
        endcase
        res.status    = fail ? STATUS_FAIL : STATUS_OK;
        res.is_empty  = (heap_size == 0);
        res.top_data  = (heap_size == 0) ? '0 : heap_slot[0].data;
        res.top_key   = (heap_size == 0) ? '0 : heap_slot[0].key;
        res.occupancy = OCC_W'(heap_size);
        return res;
    endfunction

    task automatic check_response(rsp_t got);
        rsp_t want;
        if (results_due.size() == 0) begin
            report_mismatch("response with no item outstanding");
            return;
        end
        want = results_due.pop_front();
        if (got.status !== want.status)
            report_mismatch($sformatf("status: got %0d, expected %0d",
                                      got.status, want.status));
        if (got.is_empty !== want.is_empty)
            report_mismatch($sformatf("is_empty: got %0d, expected %0d",
                                      got.is_empty, want.is_empty));
        if (got.top_data !== want.top_data)
            report_mismatch($sformatf("top_data: got %h, expected %h",
                                      got.top_data, want.top_data));
        if (got.top_key !== want.top_key)
            report_mismatch($sformatf("top_key: got %h, expected %h",
                                      got.top_key, want.top_key));
        if (got.occupancy !== want.occupancy)
            report_mismatch($sformatf("occupancy: got %0d, expected %0d",
                                      got.occupancy, want.occupancy));
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            heap_size = 0;
            results_due.delete();
        end else begin
            // an older item's response is checked before a new item is queued
            if (rsp_valid && !rsp_stall)
                check_response(rsp);
            if (req_valid && !req_stall)
                results_due.push_back(heap_result(req));
        end
        mismatches  <= error_total;
        outstanding <= results_due.size();
    end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the max-heap queue unit with directed and random items under
// several idling and stall patterns; bmhpq_checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;
    import bmhpq_pkg::*;

    localparam int         HEAP_DEPTH    = 256;
    localparam int         OVERFLOW_OPS  = 6;     // inserts past full, removes past empty
    localparam int         PRESSURE_HOLD = 300;   // receiver hold-off in cycles
    localparam int         STALL_LIMIT   = 5000;  // cycles with no handshake at all
    localparam int         DRAIN_CYCLES  = 20;    // settle time after the checker has nothing outstanding
    localparam logic [1:0] FUNC_SPARE    = 2'd3;  // unused code, acts as peek

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    int fail_count;
    int outstanding;

    // knobs shared by the stimulus and the response side
    int send_idle_pct = 0;
    int rsp_stall_pct = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    always #5 clk = ~clk;

    binary_max_heap_priority_queue_unit #(
        .CAPACITY (HEAP_DEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    bmhpq_checker #(
        .DEPTH (HEAP_DEPTH)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .mismatches  (fail_count),
        .outstanding (outstanding)
    );

    // Response side: a pending hold-off wins, otherwise stall at random.
    // The hold-off is what lets the unit back up and stall its input.
    initial begin
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                hold_left--;
                rsp_stall <= 1'b1;
            end else
                rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
        end
    end

    // Watchdog: any handshake on either channel counts as progress.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic req_t make_req(logic [1:0] func, logic [31:0] key,
                                      logic [31:0] payload);
        req_t r;
        r.func    = func;
        r.key     = key;
        r.payload = payload;
        return r;
    endfunction

    // Mix of key spreads: a dense band for lots of ties, the corners,
    // and the full 32-bit range.
    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 7) - 4;
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    // Remove/peek still carry random key and payload: the unit must ignore them.
    function automatic req_t random_req(int insert_pct);
        int         roll;
        logic [1:0] func;
        roll = $urandom_range(0, 99);
        if (roll < insert_pct)
            func = FUNC_INSERT;
        else if (roll < 90)
            func = FUNC_REMOVE;
        else if (roll < 97)
            func = FUNC_PEEK;
        else
            func = FUNC_SPARE;
        return make_req(func, pick_key(), $urandom());
    endfunction

    // Offer one item and hold it until taken. Valid only drops when an
    // idle gap follows, so there is never a low/high pair in one step.
    task automatic send_item(req_t item);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task automatic run_mixed(int count, int insert_pct);
        repeat (count)
            send_item(random_req(insert_pct));
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed: no idling on either side ---
        // empty heap: every non-insert fails
        send_item(make_req(FUNC_PEEK,   32'h0,         32'h0));
        send_item(make_req(FUNC_REMOVE, 32'hffff_ffff, 32'hffff_ffff));
        send_item(make_req(FUNC_SPARE,  32'h1234_5678, 32'h9abc_def0));
        // key and payload corners; the repeated max key must not move up
        send_item(make_req(FUNC_INSERT, 32'h8000_0000, 32'h7fff_ffff));
        send_item(make_req(FUNC_INSERT, 32'h7fff_ffff, 32'h8000_0000));
        send_item(make_req(FUNC_INSERT, 32'h0000_0000, 32'h0000_0000));
        send_item(make_req(FUNC_INSERT, 32'hffff_ffff, 32'hffff_ffff));
        send_item(make_req(FUNC_INSERT, 32'h7fff_ffff, 32'h5555_5555));
        send_item(make_req(FUNC_PEEK,   32'haaaa_aaaa, 32'h5555_5555));
        send_item(make_req(FUNC_SPARE,  32'h5555_5555, 32'haaaa_aaaa));
        // drain to empty, then one remove too many
        repeat (6)
            send_item(make_req(FUNC_REMOVE, 32'h0, 32'h0));
        // equal children after a remove: the right one must come up
        send_item(make_req(FUNC_INSERT, 32'd100, 32'h1111_1111));
        send_item(make_req(FUNC_INSERT, 32'd50,  32'h2222_2222));
        send_item(make_req(FUNC_INSERT, 32'd50,  32'h3333_3333));
        send_item(make_req(FUNC_INSERT, 32'd10,  32'h4444_4444));
        repeat (4)
            send_item(make_req(FUNC_REMOVE, 32'h0, 32'h0));

        // --- fill past capacity, then drain past empty, peeking now and then ---
        for (int i = 0; i < HEAP_DEPTH + OVERFLOW_OPS; i++) begin
            if (i % 16 == 0)
                send_item(make_req(FUNC_PEEK, $urandom(), $urandom()));
            send_item(make_req(FUNC_INSERT, pick_key(), $urandom()));
        end
        for (int i = 0; i < HEAP_DEPTH + OVERFLOW_OPS; i++) begin
            if (i % 16 == 0)
                send_item(make_req(FUNC_PEEK, $urandom(), $urandom()));
            send_item(make_req(FUNC_REMOVE, $urandom(), $urandom()));
        end

        // --- sender idles most of the time ---
        send_idle_pct = 78;
        rsp_stall_pct = 0;
        run_mixed(150, 55);

        // --- receiver stalls most of the time ---
        send_idle_pct = 0;
        rsp_stall_pct = 78;
        run_mixed(150, 55);

        // --- both sides idle now and then, heap growing ---
        send_idle_pct = 25;
        rsp_stall_pct = 25;
        run_mixed(150, 65);

        // --- long receiver hold-off with the sender pushing back to back ---
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        hold_left     = PRESSURE_HOLD;
        run_mixed(40, 60);

        // --- closing stretch at full rate ---
        run_mixed(100, 50);

        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
